// ===== hdl/xrdlrr_pkg.sv =====
// ----------------------------------------------------------------------------
// xrdlrr_pkg
// Shared types and constants of the RTCP XR DLRR round trip time parser.
// ----------------------------------------------------------------------------
package xrdlrr_pkg;

  localparam int MaxPacketBytes = 2048;

  // work queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] XrPacketType  = 8'd207;
  localparam logic [7:0] DlrrBlockType = 8'd5;

  // result kinds
  localparam logic [2:0] KindRtt      = 3'd0;
  localparam logic [2:0] KindOk       = 3'd1;
  localparam logic [2:0] KindBadType  = 3'd2;
  localparam logic [2:0] KindLenErr   = 3'd3;
  localparam logic [2:0] KindBlockErr = 3'd4;
  localparam logic [2:0] KindNone     = 3'd0;  // no error latched

  // one queued job: an rtt report, a status, or both (report first)
  typedef struct packed {
    logic        rpt;
    logic [31:0] ssrc;
    logic [31:0] diff;
    logic        sts;
    logic [2:0]  sts_kind;
  } job_t;

endpackage

// ===== hdl/xrdlrr_front.sv =====
// ----------------------------------------------------------------------------
// xrdlrr_front
// Byte walker: header checks, block walk, DLRR sub-block capture. Hands one
// job per byte that causes a result to the work queue.
// ----------------------------------------------------------------------------
module xrdlrr_front import xrdlrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] packet_length_i,
  input  logic [31:0] now_ntp_i,
  input  logic        end_of_packet_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam logic [1:0] PhHead = 2'd0;
  localparam logic [1:0] PhBhdr = 2'd1;
  localparam logic [1:0] PhBody = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  localparam logic [11:0] OffMax = 12'hFFF;

  logic [11:0] off_q, off_d;
  logic [11:0] decl_q, decl_d;
  logic [11:0] buf_q, buf_d;
  logic [7:0]  btype_q, btype_d;
  logic [11:0] bend_q, bend_d;
  logic [31:0] fs_q, fs_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic [31:0] lrr_q, lrr_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] now_q, now_d;
  logic [2:0]  err_q, err_d;
  logic [1:0]  ph_q, ph_d;

  logic [18:0] len_bytes;
  logic [18:0] blk_end;
  logic [31:0] fs_shift;
  logic [11:0] buf_cap;
  logic        rpt;
  logic        sts;
  logic [2:0]  sts_kind;

  // (len + 1) * 4 from the previous byte and this one
  assign len_bytes = {1'b0, fs_q[7:0], data_byte_i, 2'b00} + 19'd4;
  assign blk_end   = {7'd0, off_q} - 19'd3 + len_bytes;
  assign fs_shift  = {fs_q[23:0], data_byte_i};
  assign buf_cap   = ({5'd0, packet_length_i} > 17'(MaxPacketBytes)) ?
                     12'(MaxPacketBytes) : packet_length_i;

  always_comb begin
    off_d    = off_q;
    decl_d   = decl_q;
    buf_d    = buf_q;
    btype_d  = btype_q;
    bend_d   = bend_q;
    fs_d     = fs_q;
    ssrc_d   = ssrc_q;
    lrr_d    = lrr_q;
    cnt_d    = cnt_q;
    now_d    = now_q;
    err_d    = err_q;
    ph_d     = ph_q;
    rpt      = 1'b0;
    sts      = 1'b0;
    sts_kind = KindOk;

    if (off_q == 12'd0) begin
      buf_d   = buf_cap;
      now_d   = now_ntp_i;
      err_d   = KindNone;
      decl_d  = '0;
      btype_d = '0;
      bend_d  = '0;
      fs_d    = '0;
      cnt_d   = '0;
      ph_d    = PhHead;
    end

    if (err_d == KindNone && off_q != OffMax) begin
      if (off_q == 12'd1) begin
        if (data_byte_i != XrPacketType) err_d = KindBadType;
      end else if (off_q == 12'd2) begin
        fs_d = {24'd0, data_byte_i};
      end else if (off_q == 12'd3) begin
        if (len_bytes > {7'd0, buf_d}) begin
          err_d = KindLenErr;
        end else begin
          decl_d = len_bytes[11:0];
          bend_d = 12'd8;
          ph_d   = PhBhdr;
          cnt_d  = '0;
        end
      end else if (off_q >= 12'd8) begin
        if (ph_d == PhBody && off_q >= bend_d) begin
          ph_d  = PhBhdr;
          cnt_d = '0;
        end
        if (ph_d == PhBhdr) begin
          case (cnt_d)
            4'd0: begin
              if ({1'b0, off_q} + 13'd4 < {1'b0, decl_d}) begin
                btype_d = data_byte_i;
                cnt_d   = 4'd1;
              end else begin
                ph_d = PhDone;
              end
            end
            4'd1: cnt_d = 4'd2;
            4'd2: begin
              fs_d  = {24'd0, data_byte_i};
              cnt_d = 4'd3;
            end
            default: begin
              if (blk_end > {7'd0, buf_d}) begin
                err_d = KindBlockErr;
              end else begin
                bend_d = blk_end[11:0];
                ph_d   = PhBody;
                cnt_d  = '0;
              end
            end
          endcase
        end else if (ph_d == PhBody && btype_d == DlrrBlockType) begin
          fs_d  = fs_shift;
          cnt_d = cnt_d + 4'd1;
          if (cnt_d == 4'd4) begin
            ssrc_d = fs_shift;
          end else if (cnt_d == 4'd8) begin
            lrr_d = fs_shift;
          end else if (cnt_d >= 4'd12) begin
            rpt   = 1'b1;
            cnt_d = '0;
          end
        end
      end
    end

    if (end_of_packet_i) begin
      sts = 1'b1;
      if (err_d == KindNone) begin
        if (off_q == 12'd0)     err_d = KindBadType;
        else if (off_q < 12'd3) err_d = KindLenErr;
      end
      sts_kind = (err_d != KindNone) ? err_d : KindOk;
      off_d    = '0;
    end else if (off_q != OffMax) begin
      off_d = off_q + 12'd1;
    end
  end

  assign push_o         = accept_i && (rpt || sts);
  assign job_o.rpt      = rpt;
  assign job_o.ssrc     = ssrc_q;
  assign job_o.diff     = now_q - lrr_q - fs_shift;  // DLRR is the word just completed
  assign job_o.sts      = sts;
  assign job_o.sts_kind = sts_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      decl_q  <= '0;
      buf_q   <= '0;
      btype_q <= '0;
      bend_q  <= '0;
      fs_q    <= '0;
      ssrc_q  <= '0;
      lrr_q   <= '0;
      cnt_q   <= '0;
      now_q   <= '0;
      err_q   <= KindNone;
      ph_q    <= PhHead;
    end else if (accept_i) begin
      off_q   <= off_d;
      decl_q  <= decl_d;
      buf_q   <= buf_d;
      btype_q <= btype_d;
      bend_q  <= bend_d;
      fs_q    <= fs_d;
      ssrc_q  <= ssrc_d;
      lrr_q   <= lrr_d;
      cnt_q   <= cnt_d;
      now_q   <= now_d;
      err_q   <= err_d;
      ph_q    <= ph_d;
    end
  end

endmodule

// ===== hdl/xrdlrr_queue.sv =====
// ----------------------------------------------------------------------------
// xrdlrr_queue
// Short job queue between the byte walker and the rtt back end.
// ----------------------------------------------------------------------------
module xrdlrr_queue import xrdlrr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t head_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

// ===== hdl/xrdlrr_back.sv =====
// ----------------------------------------------------------------------------
// xrdlrr_back
// Scales the time difference to ms and drives the result register. A job with
// both a report and a status gives two results, report first.
// ----------------------------------------------------------------------------
module xrdlrr_back import xrdlrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  job_t               q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [31:0]        ssrc_o,
  output logic signed [25:0] rtt_ms_o,
  output logic               last_o
);

  typedef struct packed {
    logic               rpt;
    logic [31:0]        ssrc;
    logic signed [41:0] prod;
    logic               sts;
    logic [2:0]         sts_kind;
  } ex_t;

  ex_t                ex_q;
  logic               ex_valid_q;
  logic               out_valid_q;
  logic               take;
  logic               ex_done;
  logic signed [41:0] prod;

  // diff * 1000; the arithmetic shift by 16 below floors toward minus infinity
  assign prod = 42'(signed'(q_head_i.diff)) * 42'sd1000;

  assign take    = ex_valid_q && (!out_valid_q || !out_stall_i);
  assign ex_done = take && !(ex_q.rpt && ex_q.sts);
  assign q_pop_o = q_valid_i && (!ex_valid_q || ex_done);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ex_q.rpt      <= q_head_i.rpt;
      ex_q.ssrc     <= q_head_i.ssrc;
      ex_q.prod     <= prod;
      ex_q.sts      <= q_head_i.sts;
      ex_q.sts_kind <= q_head_i.sts_kind;
    end else if (take) begin
      ex_q.rpt <= 1'b0;  // report sent, status follows
    end
    if (take) begin
      if (ex_q.rpt) begin
        kind_o   <= KindRtt;
        ssrc_o   <= ex_q.ssrc;
        rtt_ms_o <= ex_q.prod[41:16];
        last_o   <= 1'b0;
      end else begin
        kind_o   <= ex_q.sts_kind;
        ssrc_o   <= '0;
        rtt_ms_o <= '0;
        last_o   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o)      ex_valid_q <= 1'b1;
      else if (ex_done) ex_valid_q <= 1'b0;
      if (take)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_split_keeps_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && ex_q.rpt && ex_q.sts) |=> (ex_valid_q && !ex_q.rpt && ex_q.sts))
    else $error("status lost after report");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_o) |-> (ssrc_o == '0 && rtt_ms_o == '0 && kind_o != KindRtt))
    else $error("status result carries report fields");

endmodule

// ===== hdl/rtcp_xr_dlrr_rtt_parser.sv =====
// ----------------------------------------------------------------------------
// rtcp_xr_dlrr_rtt_parser
// RTCP XR parser that reports the round trip time of every DLRR sub-block.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | data_byte, packet_length, now_ntp, eop
//  out     | out_valid_o/out_stall_i | kind, ssrc, rtt_ms, last
//
//  One byte per cycle while not stalled; the walker updates its state in the
//  cycle of acceptance. A result passes the job queue, the multiply stage and
//  then the result register. A byte that ends a sub-block and the packet gives
//  two results and holds the back end until both are taken.
//  Input stalls only when the four-entry job queue is full.
//  Reset clears the walk and the queue; no startup sweep.
// ----------------------------------------------------------------------------
module rtcp_xr_dlrr_rtt_parser import xrdlrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic [11:0]        packet_length_i,
  input  logic [31:0]        now_ntp_i,
  input  logic               end_of_packet_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [31:0]        ssrc_o,
  output logic signed [25:0] rtt_ms_o,
  output logic               last_o
);

  logic accept;
  logic push;
  job_t job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  xrdlrr_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .data_byte_i,
    .packet_length_i,
    .now_ntp_i,
    .end_of_packet_i,
    .push_o          (push),
    .job_o           (job)
  );

  xrdlrr_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  xrdlrr_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .ssrc_o,
    .rtt_ms_o,
    .last_o
  );

endmodule
